@@ hw/rtl/multimode_lowpass_filter_assert.svh @@
// assertion macros for the multimode lowpass filter checker
`ifndef MULTIMODE_LOWPASS_FILTER_ASSERT_SVH
`define MULTIMODE_LOWPASS_FILTER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MMLPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define MMLPF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/mmlpf_pkg.sv @@
// shared constants, types and helpers of the multimode lowpass filter
`timescale 1ns / 1ps
`default_nettype none
package mmlpf_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int MAX_STAGES_DEF  = 4;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int FRAC      = 21;
  localparam int GAIN_FRAC = 12;
  localparam int COEF_W    = 24;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 34;
  localparam int P_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = P_W + 1;

  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 28;
  localparam int DIV_Q_W   = 25;

  localparam logic [1:0] MODE_LADDER = 2'd1;
  localparam logic [1:0] MODE_SVF    = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_GAIN      = 3'd1,
    REG_B0        = 3'd2,
    REG_A1        = 3'd3,
    REG_A2        = 3'd4,
    REG_FREQ      = 3'd5,
    REG_DAMPING   = 3'd6,
    REG_STAGES    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'h7fffffff;
    end else if (v < lo) begin
      sat32 = 32'h80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mmlpf_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module mmlpf_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mmlpf_pkg::div_req_t req_i,
  output mmlpf_pkg::div_rsp_t      rsp_o
);
  import mmlpf_pkg::*;

  localparam int CNT_W = $clog2(DIV_Q_W);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_Q_W-1:0]   sh_q, sh_d;
  logic [DIV_Q_W-1:0]   quot_q, quot_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   trial;

  // quotient is known to fit DIV_Q_W bits, so the top part starts below den
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quot_d = quot_q;
    den_d  = den_q;
    trial  = {rem_q, sh_q[DIV_Q_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = DIV_DEN_W'(req_i.num[DIV_NUM_W-1:DIV_Q_W]);
      sh_d   = req_i.num[DIV_Q_W-1:0];
      den_d  = req_i.den;
      quot_d = '0;
    end else if (busy_q) begin
      sh_d = {sh_q[DIV_Q_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d  = DIV_DEN_W'(trial - {1'b0, den_q});
        quot_d = {quot_q[DIV_Q_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DIV_DEN_W-1:0];
        quot_d = {quot_q[DIV_Q_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_Q_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
`default_nettype wire

@@ hw/rtl/multimode_lowpass_filter.sv @@
// top level of the multimode lowpass filter
`timescale 1ns / 1ps
`default_nettype none
// Multimode lowpass filter for CHANNELS channels of signed Q3.21 audio. Each
// input item (channel, sample) yields one result item with the same channel
// and the filtered sample, saturated to SAMPLE_BITS. The sample is scaled by
// input_gain (unsigned Q4.12) and filtered as a biquad lowpass followed by a
// tanh saturator (mode 0 or 3), a tanh ladder of 1..MAX_STAGES stages whose
// outputs are averaged (mode 1), or one Chamberlin state-variable step
// (mode 2). All arithmetic runs through one shared 25x34 signed multiplier
// and one shared 25-step restoring divider under a one-hot sequencer, so the
// block takes one item at a time: in_ready_o is high only while it is idle.
// Per item, the biquad path runs the filter, then the tanh, then hands over;
// the ladder runs one tanh per stage; each tanh waits on its 25-step
// division, which dominates. A finished result waits in an output register,
// so the next item can be taken while it is still pending.
// Configuration writes are always accepted and must only happen while idle.
module multimode_lowpass_filter #(
  parameter int CHANNELS    = mmlpf_pkg::CHANNELS_DEF,
  parameter int MAX_STAGES  = mmlpf_pkg::MAX_STAGES_DEF,
  parameter int SAMPLE_BITS = mmlpf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              channel_i,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   channel_out_o,
  output logic signed [SAMPLE_BITS-1:0]          sample_out_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mmlpf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mmlpf_pkg::CFG_DAT_W-1:0]   cfg_data_i
);
  import mmlpf_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = 4;
  localparam int ST_W  = 24;
  localparam int M_W   = 23;
  localparam int NB_W  = 27;
  localparam logic [M_W-1:0]       TANH_LIM = M_W'(3 << FRAC);
  localparam logic [DIV_DEN_W-1:0] K27      = DIV_DEN_W'(27 << FRAC);
  localparam logic signed [32:0]   SMAX =
    33'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [32:0]   SMIN = -SMAX - 33'sd1;

  // sequencer states, one-hot
  typedef enum logic [ST_W-1:0] {
    S_IDLE   = ST_W'(1) << 0,
    S_GAIN   = ST_W'(1) << 1,
    S_XSAT   = ST_W'(1) << 2,
    S_BQ     = ST_W'(1) << 3,
    S_BQEND  = ST_W'(1) << 4,
    S_LDMUL  = ST_W'(1) << 5,
    S_LDSAT  = ST_W'(1) << 6,
    S_LDACC  = ST_W'(1) << 7,
    S_LDDIV  = ST_W'(1) << 8,
    S_LDWAIT = ST_W'(1) << 9,
    S_SV0    = ST_W'(1) << 10,
    S_SV1    = ST_W'(1) << 11,
    S_SV2    = ST_W'(1) << 12,
    S_SV3    = ST_W'(1) << 13,
    S_SV4    = ST_W'(1) << 14,
    S_SV5    = ST_W'(1) << 15,
    S_SV6    = ST_W'(1) << 16,
    S_T0     = ST_W'(1) << 17,
    S_T1     = ST_W'(1) << 18,
    S_T2     = ST_W'(1) << 19,
    S_T3     = ST_W'(1) << 20,
    S_T4     = ST_W'(1) << 21,
    S_TWAIT  = ST_W'(1) << 22,
    S_FIN    = ST_W'(1) << 23
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  // configuration registers
  logic [1:0]               mode_q;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [COEF_W-1:0] b0_q, a1_q, a2_q, fc_q, damp_q;
  logic [2:0]               stages_q;

  // per-channel filter state
  logic signed [31:0] x1_q [CHANNELS];
  logic signed [31:0] x2_q [CHANNELS];
  logic signed [31:0] y1_q [CHANNELS];
  logic signed [31:0] y2_q [CHANNELS];
  logic signed [31:0] lps_q [CHANNELS];
  logic signed [31:0] bps_q [CHANNELS];

  // working registers of the item in flight
  logic                          chan_q, chan_d;
  logic [CH_W-1:0]               c_q, c_d;
  logic signed [SAMPLE_BITS-1:0] s_q, s_d;
  logic signed [31:0]            x_q, x_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [CNT_W-1:0]              n_q, n_d;
  logic signed [ACC_W-1:0]       acc_q, acc_d;
  logic signed [31:0]            stage_q, stage_d;
  logic signed [31:0]            lp_q, lp_d;
  logic signed [31:0]            bp_q, bp_d;
  logic signed [31:0]            hp_q, hp_d;
  logic signed [31:0]            targ_q, targ_d;
  logic signed [31:0]            tres_q, tres_d;
  logic signed [31:0]            y_q, y_d;
  logic [M_W-1:0]                m_q, m_d;
  logic                          neg_q, neg_d;
  logic [DIV_DEN_W-1:0]          den_q, den_d;
  logic [NB_W-1:0]               nb_q, nb_d;
  logic signed [P_W-1:0]         p_q, p_d;

  // output register
  logic                          ovalid_q, ovalid_d;
  logic                          ochan_q, ochan_d;
  logic signed [SAMPLE_BITS-1:0] osamp_q, osamp_d;

  // shared multiplier operands
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  // state write strobes
  logic bq_wr, lp_wr, bp_wr;
  logic signed [31:0] v_w;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [P_W-FRAC-1:0] mq;
  logic                       accept;
  logic [32:0]                tmag;
  logic [ACC_W-1:0]           amag;
  logic [24:0]                m2;
  logic signed [DIV_Q_W:0]    qs;
  logic [CNT_W-1:0]           n_cl;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign mq          = (P_W-FRAC)'(p_q >>> FRAC);
  assign qs          = $signed({1'b0, div_rsp.quot});

  // clamped stage count
  always_comb begin
    if (stages_q == 3'd0) begin
      n_cl = CNT_W'(1);
    end else if (CNT_W'(stages_q) > CNT_W'(MAX_STAGES)) begin
      n_cl = CNT_W'(MAX_STAGES);
    end else begin
      n_cl = CNT_W'(stages_q);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_GAIN: begin
        mul_a = MUL_A_W'($signed({1'b0, gain_q}));
        mul_b = MUL_B_W'(s_q);
      end
      S_BQ: begin
        // b1 = 2*b0, feedback terms negated so every product just adds
        unique case (cnt_q)
          CNT_W'(0): begin
            mul_a = MUL_A_W'(b0_q);
            mul_b = MUL_B_W'(x_q);
          end
          CNT_W'(1): begin
            mul_a = MUL_A_W'(b0_q) <<< 1;
            mul_b = MUL_B_W'(x1_q[c_q]);
          end
          CNT_W'(2): begin
            mul_a = MUL_A_W'(b0_q);
            mul_b = MUL_B_W'(x2_q[c_q]);
          end
          CNT_W'(3): begin
            mul_a = -MUL_A_W'(a1_q);
            mul_b = MUL_B_W'(y1_q[c_q]);
          end
          CNT_W'(4): begin
            mul_a = -MUL_A_W'(a2_q);
            mul_b = MUL_B_W'(y2_q[c_q]);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      S_LDMUL: begin
        mul_a = MUL_A_W'(fc_q);
        mul_b = MUL_B_W'(stage_q) + MUL_B_W'(x_q) - MUL_B_W'(lp_q);
      end
      S_SV0, S_SV5: begin
        mul_a = MUL_A_W'(fc_q);
        mul_b = MUL_B_W'(bp_q);
      end
      S_SV1: begin
        mul_a = MUL_A_W'(damp_q);
        mul_b = MUL_B_W'(bp_q);
      end
      S_SV3: begin
        mul_a = MUL_A_W'(fc_q);
        mul_b = MUL_B_W'(hp_q);
      end
      S_T1: begin
        mul_a = $signed(MUL_A_W'(m_q));
        mul_b = $signed(MUL_B_W'(m_q));
      end
      S_T3: begin
        mul_a = $signed(MUL_A_W'(m_q));
        mul_b = $signed(MUL_B_W'(nb_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_d = mul_a * mul_b;

  // sequencer
  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    chan_d   = chan_q;
    c_d      = c_q;
    s_d      = s_q;
    x_d      = x_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    acc_d    = acc_q;
    stage_d  = stage_q;
    lp_d     = lp_q;
    bp_d     = bp_q;
    hp_d     = hp_q;
    targ_d   = targ_q;
    tres_d   = tres_q;
    y_d      = y_q;
    m_d      = m_q;
    neg_d    = neg_q;
    den_d    = den_q;
    nb_d     = nb_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ochan_d  = ochan_q;
    osamp_d  = osamp_q;
    bq_wr    = 1'b0;
    lp_wr    = 1'b0;
    bp_wr    = 1'b0;
    v_w      = sat32(64'(acc_q >>> FRAC));
    tmag     = '0;
    amag     = '0;
    m2       = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          chan_d  = channel_i;
          c_d     = (CHANNELS > 1) ? CH_W'(channel_i) : '0;
          s_d     = sample_in_i;
          state_d = S_GAIN;
        end
      end
      S_GAIN: state_d = S_XSAT;
      S_XSAT: begin
        // drive gain, Q4.12
        x_d   = sat32(64'(p_q >>> GAIN_FRAC));
        acc_d = '0;
        cnt_d = '0;
        lp_d  = lps_q[c_q];
        bp_d  = bps_q[c_q];
        n_d   = n_cl;
        if (mode_q == MODE_LADDER) begin
          stage_d = sat32(64'(p_q >>> GAIN_FRAC));
          state_d = S_LDMUL;
        end else if (mode_q == MODE_SVF) begin
          state_d = S_SV0;
        end else begin
          state_d = S_BQ;
        end
      end
      S_BQ: begin
        if (cnt_q != '0) begin
          acc_d = acc_q + ACC_W'(p_q);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(5)) begin
          state_d = S_BQEND;
        end
      end
      S_BQEND: begin
        bq_wr   = 1'b1;
        targ_d  = v_w;
        ret_d   = S_FIN;
        state_d = S_T0;
      end
      S_LDMUL: state_d = S_LDSAT;
      S_LDSAT: begin
        stage_d = sat32(64'(mq));
        targ_d  = sat32(64'(mq));
        ret_d   = S_LDACC;
        state_d = S_T0;
      end
      S_LDACC: begin
        lp_d  = tres_q;
        acc_d = acc_q + ACC_W'(tres_q);
        if (cnt_q == n_q - 1'b1) begin
          state_d = S_LDDIV;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_LDMUL;
        end
      end
      S_LDDIV: begin
        // lp register already holds the last tanh output
        lp_wr = 1'b1;
        amag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
        div_req.start = 1'b1;
        div_req.num   = amag[DIV_NUM_W-1:0];
        div_req.den   = DIV_DEN_W'(n_q);
        state_d = S_LDWAIT;
      end
      S_LDWAIT: begin
        if (div_rsp.done) begin
          // average truncated toward zero
          y_d     = acc_q[ACC_W-1] ? -32'(qs) : 32'(qs);
          state_d = S_FIN;
        end
      end
      S_SV0: state_d = S_SV1;
      S_SV1: begin
        lp_d    = sat32(64'(lp_q) + 64'(mq));
        state_d = S_SV2;
      end
      S_SV2: begin
        hp_d    = sat32(64'(x_q) - 64'(lp_q) - 64'(mq));
        state_d = S_SV3;
      end
      S_SV3: state_d = S_SV4;
      S_SV4: begin
        bp_d    = sat32(64'(bp_q) + 64'(mq));
        state_d = S_SV5;
      end
      S_SV5: state_d = S_SV6;
      S_SV6: begin
        lp_d    = sat32(64'(lp_q) + 64'(mq));
        y_d     = sat32(64'(lp_q) + 64'(mq));
        lp_wr   = 1'b1;
        bp_wr   = 1'b1;
        state_d = S_FIN;
      end
      S_T0: begin
        // magnitude clamped to 3.0
        neg_d = targ_q[31];
        tmag  = targ_q[31] ? 33'(-(33'(targ_q))) : 33'(targ_q);
        m_d   = (tmag > 33'(TANH_LIM)) ? TANH_LIM : tmag[M_W-1:0];
        state_d = S_T1;
      end
      S_T1: state_d = S_T2;
      S_T2: begin
        m2      = p_q[FRAC+24:FRAC];
        den_d   = K27 + DIV_DEN_W'(m2) + (DIV_DEN_W'(m2) << 3);
        nb_d    = NB_W'(K27) + NB_W'(m2);
        state_d = S_T3;
      end
      S_T3: state_d = S_T4;
      S_T4: begin
        div_req.start = 1'b1;
        div_req.num   = p_q[DIV_NUM_W-1:0];
        div_req.den   = den_q;
        state_d = S_TWAIT;
      end
      S_TWAIT: begin
        if (div_rsp.done) begin
          tres_d  = neg_q ? -32'(qs) : 32'(qs);
          y_d     = neg_q ? -32'(qs) : 32'(qs);
          state_d = ret_q;
        end
      end
      S_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ochan_d  = chan_q;
          if (33'(y_q) > SMAX) begin
            osamp_d = SAMPLE_BITS'(SMAX);
          end else if (33'(y_q) < SMIN) begin
            osamp_d = SAMPLE_BITS'(SMIN);
          end else begin
            osamp_d = SAMPLE_BITS'(y_q);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  mmlpf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_FIN;
      ovalid_q <= 1'b0;
      mode_q   <= 2'd0;
      gain_q   <= GAIN_W'(4096);
      b0_q     <= '0;
      a1_q     <= '0;
      a2_q     <= '0;
      fc_q     <= '0;
      damp_q   <= COEF_W'(1 << FRAC);
      stages_q <= 3'd1;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_MODE:    mode_q   <= cfg_data_i[1:0];
          REG_GAIN:    gain_q   <= cfg_data_i[GAIN_W-1:0];
          REG_B0:      b0_q     <= cfg_data_i;
          REG_A1:      a1_q     <= cfg_data_i;
          REG_A2:      a2_q     <= cfg_data_i;
          REG_FREQ:    fc_q     <= cfg_data_i;
          REG_DAMPING: damp_q   <= cfg_data_i;
          REG_STAGES:  stages_q <= cfg_data_i[2:0];
          default:     mode_q   <= mode_q;
        endcase
      end
    end
  end

  // per-channel state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        x1_q[i]  <= '0;
        x2_q[i]  <= '0;
        y1_q[i]  <= '0;
        y2_q[i]  <= '0;
        lps_q[i] <= '0;
        bps_q[i] <= '0;
      end
    end else begin
      if (bq_wr) begin
        x2_q[c_q] <= x1_q[c_q];
        x1_q[c_q] <= x_q;
        y2_q[c_q] <= y1_q[c_q];
        y1_q[c_q] <= v_w;
      end
      if (lp_wr) begin
        lps_q[c_q] <= lp_d;
      end
      if (bp_wr) begin
        bps_q[c_q] <= bp_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    chan_q  <= chan_d;
    c_q     <= c_d;
    s_q     <= s_d;
    x_q     <= x_d;
    cnt_q   <= cnt_d;
    n_q     <= n_d;
    acc_q   <= acc_d;
    stage_q <= stage_d;
    lp_q    <= lp_d;
    bp_q    <= bp_d;
    hp_q    <= hp_d;
    targ_q  <= targ_d;
    tres_q  <= tres_d;
    y_q     <= y_d;
    m_q     <= m_d;
    neg_q   <= neg_d;
    den_q   <= den_d;
    nb_q    <= nb_d;
    p_q     <= p_d;
    ochan_q <= ochan_d;
    osamp_q <= osamp_d;
  end

  assign out_valid_o   = ovalid_q;
  assign channel_out_o = ochan_q;
  assign sample_out_o  = osamp_q;

endmodule
`default_nettype wire

@@ hw/rtl/mmlpf_checker.sv @@
// port-level checker for the multimode lowpass filter, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "multimode_lowpass_filter_assert.svh"
module mmlpf_port_checker #(
  parameter int SAMPLE_BITS = mmlpf_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic                          channel_out_o,
  input wire logic signed [SAMPLE_BITS-1:0] sample_out_o
);
  // an accepted item keeps the block busy
  `MMLPF_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // a new result only appears at the end of work on an item
  `MMLPF_ASSERT_IMP(a_result_after_work, $rose(out_valid_o), !$past(in_ready_o))
  // a stalled result holds
  `MMLPF_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(sample_out_o) && $stable(channel_out_o))
endmodule

bind multimode_lowpass_filter mmlpf_port_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mmlpf_checker (.*);
`default_nettype wire
